### hw/rtl/lfi_pkg.sv
// Package for length field inference: candidate geometry and shared types.
// Used by all modules under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none
package lfi_pkg;
	localparam int PROBE_BYTES_DEF = 16;
	localparam int MAX_MESSAGES = 65536;
	localparam int LENGTH_BITS = 16;
	localparam int MIN_SAMPLES = 4;
	localparam int CNT_W = 17;
	localparam int K_W = 17;

	// register byte addresses on the APB port
	localparam logic [1:0] REG_MIN_COV = 2'd0;

	// candidate index c -> width code and offset; endian is the low bit of c
	function automatic logic [2:0] cand_width(input int c, input int pb);
		if (c < 2 * pb) return 3'd1;
		else if (c < 2 * pb + 2 * (pb - 1)) return 3'd2;
		else return 3'd4;
	endfunction

	function automatic logic [3:0] cand_offset(input int c, input int pb);
		int r;
		begin
			if (c < 2 * pb) r = c / 2;
			else if (c < 4 * pb - 2) r = (c - 2 * pb) / 2;
			else r = (c - 4 * pb + 2) / 2;
			return r[3:0];
		end
	endfunction

	typedef struct packed {
		logic       found;
		logic [3:0] off;
		logic [2:0] width;
		logic       be;
		logic [K_W-1:0] k;
	} pick_t;
endpackage
`default_nettype wire

### hw/rtl/lfi_lane.sv
// One candidate lane: extracts its field, tracks constant and counts.
// Depends on lfi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfi_lane import lfi_pkg::*; #(
	parameter int PROBE_BYTES = PROBE_BYTES_DEF,
	parameter int IDX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic clear,
	input  wire logic [127:0] hdr,
	input  wire logic [LENGTH_BITS-1:0] len,
	output logic seen,
	output logic [CNT_W-1:0] match_cnt,
	output logic [CNT_W-1:0] valid_cnt,
	output logic signed [K_W+LENGTH_BITS:0] kval
);
	localparam logic [2:0] W = cand_width(IDX, PROBE_BYTES);
	localparam logic [3:0] OFF = cand_offset(IDX, PROBE_BYTES);
	localparam logic BE = 1'(IDX % 2);
	localparam int KW = K_W + LENGTH_BITS + 1;
	localparam logic [CNT_W-1:0] CMAX = CNT_W'(MAX_MESSAGES);

	logic [31:0] field;
	logic signed [KW-1:0] d;
	logic fits;
	logic [CNT_W-1:0] max_v;

	// extract field bytes
	always_comb begin
		field = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < int'(W)) begin
				if (BE) field = {field[23:0], hdr[8*(int'(OFF)+i) +: 8]};
				else field[8*i +: 8] = hdr[8*(int'(OFF)+i) +: 8];
			end
		end
		fits = ((32'(OFF) + 32'(W)) <= 32'(len));
		d = KW'(signed'({1'b0, len})) - KW'(signed'({1'b0, field}));
		max_v = CMAX;
	end

	// update lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen <= 1'b0;
			match_cnt <= '0;
			valid_cnt <= '0;
		end else if (clear) begin
			seen <= 1'b0;
			match_cnt <= '0;
			valid_cnt <= '0;
		end else if (step && fits) begin
			seen <= 1'b1;
			if (valid_cnt < max_v) valid_cnt <= valid_cnt + 1'b1;
			if ((!seen || d == kval) && match_cnt < max_v) match_cnt <= match_cnt + 1'b1;
		end
	end

	// hold first constant
	always_ff @(posedge clk) begin
		if (step && fits && !seen && !clear) kval <= d;
	end
endmodule
`default_nettype wire

### hw/rtl/lfi_merge.sv
// Merge stage: walks candidates one per cycle and keeps the best.
// Depends on lfi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfi_merge import lfi_pkg::*; #(
	parameter int PROBE_BYTES = PROBE_BYTES_DEF,
	parameter int NC = 2 * (3 * PROBE_BYTES - 4)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic [6:0] pct,
	input  wire logic [NC-1:0] seen,
	input  wire logic [NC*CNT_W-1:0] mcnt,
	input  wire logic [NC*CNT_W-1:0] vcnt,
	input  wire logic [NC*(K_W+LENGTH_BITS+1)-1:0] kv,
	output logic done,
	output pick_t pick
);
	localparam int KW = K_W + LENGTH_BITS + 1;
	localparam int IW = $clog2(NC);
	logic run_q;
	logic [IW-1:0] idx_q;
	logic [CNT_W-1:0] m, v, bm_q, bv_q;
	logic signed [KW-1:0] k;
	logic [CNT_W+7:0] m100, pv;
	logic [2*CNT_W-1:0] x1, x2;
	logic ok, better;
	logic [2:0] w_lut [NC];
	logic [3:0] o_lut [NC];
	logic found_q;
	logic [3:0] off_q;
	logic [2:0] width_q;
	logic be_q;
	logic [K_W-1:0] k_q;

	assign pick = {found_q, off_q, width_q, be_q, k_q};

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			w_lut[c] = cand_width(c, PROBE_BYTES);
			o_lut[c] = cand_offset(c, PROBE_BYTES);
		end
		m = mcnt[idx_q*CNT_W +: CNT_W];
		v = vcnt[idx_q*CNT_W +: CNT_W];
		k = kv[idx_q*KW +: KW];
		m100 = (CNT_W+8)'(m) * (CNT_W+8)'(100);
		pv = (CNT_W+8)'(pct) * (CNT_W+8)'(v);
		x1 = (2*CNT_W)'(m) * (2*CNT_W)'(bv_q);
		x2 = (2*CNT_W)'(bm_q) * (2*CNT_W)'(v);
		ok = seen[idx_q] && v >= CNT_W'(MIN_SAMPLES) && m100 >= pv && k >= 0;
		better = !found_q || x1 > x2;
	end

	// scan candidates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
			done <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				idx_q <= '0;
				found_q <= 1'b0;
			end else if (run_q) begin
				if (ok && better) found_q <= 1'b1;
				if (idx_q == IW'(NC - 1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end else idx_q <= idx_q + 1'b1;
			end
		end
	end

	// hold winner payload
	always_ff @(posedge clk) begin
		if (run_q && ok && better) begin
			bm_q <= m;
			bv_q <= v;
			off_q <= o_lut[idx_q];
			width_q <= w_lut[idx_q];
			be_q <= idx_q[0];
			k_q <= k[K_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run_q)) else $error("done without scan");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> idx_q <= IW'(NC - 1)) else $error("index out of range");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !run_q) else $error("go while scanning");
`endif
endmodule
`default_nettype wire

### hw/rtl/length_field_inference.sv
// Length field inference: usage
// Channels: start/busy input command; strobe marks a one-cycle result that
// cannot be held off. APB port holds min_coverage_percent at address 0.
// Each message updates all candidate lanes in parallel, so a non-last item
// leaves busy low. A last item is folded in, then the merge stage walks the
// candidates one per cycle while busy is high, and strobe pulses at the end
// with the result, after which all counts are clear. Throughput is one item
// per cycle inside a batch; the batch end costs the candidate scan, set by
// the single merge comparator.
// Reset clears all counts and sets the coverage to 80 percent.
// Depends on lfi_pkg, lfi_lane, lfi_merge.
`timescale 1ns / 1ps
`default_nettype none
module length_field_inference import lfi_pkg::*; #(
	parameter int PROBE_BYTES = PROBE_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [63:0] header_low,
	input  wire logic [63:0] header_high,
	input  wire logic [15:0] payload_length,
	input  wire logic last_message,
	output logic strobe,
	output logic detected,
	output logic [3:0] field_offset,
	output logic [2:0] field_width,
	output logic big_endian,
	output logic signed [16:0] adjustment,
	output logic [16:0] message_total,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int NC = 2 * (3 * PROBE_BYTES - 4);
	localparam int KW = K_W + LENGTH_BITS + 1;
	localparam logic [CNT_W-1:0] CMAX = CNT_W'(MAX_MESSAGES);

	logic [6:0] pct_q;
	logic [CNT_W-1:0] batch_q;
	logic go_q, scan_q, step, clear;
	logic [NC-1:0] seen;
	logic [NC*CNT_W-1:0] mcnt, vcnt;
	logic [NC*KW-1:0] kv;
	logic done;
	pick_t pick;
	logic win;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_MIN_COV) ? {25'd0, pct_q} : 32'd0;
	assign step = start && !busy;
	assign busy = go_q || scan_q;
	assign clear = done;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pct_q <= 7'd80;
		else if (psel && penable && pwrite && paddr == REG_MIN_COV) pct_q <= pwdata[6:0];
	end

	// batch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q <= '0;
			go_q <= 1'b0;
			scan_q <= 1'b0;
		end else begin
			go_q <= step && last_message;
			if (go_q) scan_q <= 1'b1;
			else if (done) scan_q <= 1'b0;
			if (done) batch_q <= '0;
			else if (step && batch_q < CMAX) batch_q <= batch_q + 1'b1;
		end
	end

	for (genvar c = 0; c < NC; c++) begin : g_lane
		lfi_lane #(.PROBE_BYTES(PROBE_BYTES), .IDX(c)) u_lane (
			.clk(clk), .arst_n(arst_n), .step(step), .clear(clear),
			.hdr({header_high, header_low}),
			.len(payload_length[LENGTH_BITS-1:0]),
			.seen(seen[c]), .match_cnt(mcnt[c*CNT_W +: CNT_W]),
			.valid_cnt(vcnt[c*CNT_W +: CNT_W]), .kval(kv[c*KW +: KW]));
	end

	lfi_merge #(.PROBE_BYTES(PROBE_BYTES), .NC(NC)) u_merge (
		.clk(clk), .arst_n(arst_n), .go(go_q), .pct(pct_q), .seen(seen),
		.mcnt(mcnt), .vcnt(vcnt), .kv(kv), .done(done), .pick(pick));

	assign win = pick.found && batch_q >= CNT_W'(MIN_SAMPLES);
	// drive result
	always_comb begin
		strobe = done;
		detected = win;
		field_offset = win ? pick.off : 4'd0;
		field_width = win ? pick.width : 3'd0;
		big_endian = win && pick.be;
		adjustment = win ? 17'(-signed'(pick.k)) : 17'sd0;
		message_total = batch_q;
	end

`ifndef SYNTHESIS
	a_no_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !step) else $error("item taken while busy");
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> batch_q == '0) else $error("batch not cleared");
	a_strobe_go: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> scan_q) else $error("strobe outside scan");
`endif
endmodule
`default_nettype wire

### bench/tb_length_field_inference.sv
// Testbench for length_field_inference: drives message batches and APB writes,
// predicts each batch result in a scoreboard class and checks the strobed results.
// Depends on lfi_pkg and the length_field_inference RTL.
`timescale 1ns / 1ps

module tb_length_field_inference;
	import lfi_pkg::*;

	localparam int NCAND = 88;
	localparam int SAT = 65536;
	localparam int LIMIT_CYCLES = 1500000;

	typedef struct {
		logic detected;
		logic [3:0] off;
		logic [2:0] width;
		logic be;
		logic [16:0] adj;
		logic [16:0] total;
	} batch_result_t;

	// Scoreboard: per-candidate counts and the queue of expected batch results
	class batch_scoreboard;
		int unsigned cov_pct;
		int unsigned msg_count;
		bit seen[NCAND];
		longint signed konst[NCAND];
		int unsigned valid_cnt[NCAND];
		int unsigned match_cnt[NCAND];
		batch_result_t pending[$];
		int errors;

		function new();
			cov_pct = 80;
			errors = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			msg_count = 0;
			for (int c = 0; c < NCAND; c++) begin
				seen[c] = 0;
				konst[c] = 0;
				valid_cnt[c] = 0;
				match_cnt[c] = 0;
			end
		endfunction

		function int unsigned extract_field(logic [127:0] hdr, int off, int w, bit be);
			int unsigned v;
			v = 0;
			for (int i = 0; i < w; i++) begin
				if (be)
					v = (v << 8) | hdr[8*(off+i) +: 8];
				else
					v = v | (int'(hdr[8*(off+i) +: 8]) << (8*i));
			end
			return v;
		endfunction

		// Fold one accepted message in; on the last one, queue the pick
		function void note_message(logic [63:0] lo, logic [63:0] hi, logic [15:0] len,
				logic last);
			logic [127:0] hdr;
			int c, w;
			longint signed d;
			bit found;
			longint unsigned bm, bv, m, v;
			batch_result_t r;
			hdr = {hi, lo};
			c = 0;
			if (msg_count < SAT) msg_count++;
			for (int wi = 0; wi < 3; wi++) begin
				w = 1 << wi;
				for (int off = 0; off + w <= 16; off++) begin
					for (int be = 0; be < 2; be++) begin
						if (off + w <= len) begin
							d = longint'(len) - longint'(extract_field(hdr, off, w, be));
							if (!seen[c]) begin
								seen[c] = 1;
								konst[c] = d;
							end
							if (valid_cnt[c] < SAT) valid_cnt[c]++;
							if (d == konst[c] && match_cnt[c] < SAT) match_cnt[c]++;
						end
						c++;
					end
				end
			end
			if (!last) return;
			found = 0;
			bm = 0;
			bv = 1;
			r = '{default: 0};
			if (msg_count >= MIN_SAMPLES) begin
				c = 0;
				for (int wi = 0; wi < 3; wi++) begin
					w = 1 << wi;
					for (int off = 0; off + w <= 16; off++) begin
						for (int be = 0; be < 2; be++) begin
							m = match_cnt[c];
							v = valid_cnt[c];
							if (seen[c] && v >= MIN_SAMPLES && m * 100 >= cov_pct * v
									&& konst[c] >= 0 && !(found && m * bv <= bm * v)) begin
								found = 1;
								bm = m;
								bv = v;
								r.detected = 1;
								r.off = 4'(off);
								r.width = 3'(w);
								r.be = 1'(be);
								r.adj = 17'(-konst[c]);
							end
							c++;
						end
					end
				end
			end
			r.total = 17'(msg_count);
			pending.push_back(r);
			clear_counts();
		endfunction

		function void check_result(batch_result_t got);
			batch_result_t e;
			if (pending.size() == 0) begin
				$error("result with no batch pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.detected !== e.detected) begin
				$error("detected: expected %0d actual %0d", e.detected, got.detected);
				errors++;
			end
			if (got.off !== e.off) begin
				$error("field_offset: expected %0d actual %0d", e.off, got.off);
				errors++;
			end
			if (got.width !== e.width) begin
				$error("field_width: expected %0d actual %0d", e.width, got.width);
				errors++;
			end
			if (got.be !== e.be) begin
				$error("big_endian: expected %0d actual %0d", e.be, got.be);
				errors++;
			end
			if (got.adj !== e.adj) begin
				$error("adjustment: expected %0d actual %0d", $signed(e.adj),
					$signed(got.adj));
				errors++;
			end
			if (got.total !== e.total) begin
				$error("message_total: expected %0d actual %0d", e.total, got.total);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy;
	logic [63:0] header_low, header_high;
	logic [15:0] payload_length;
	logic last_message, strobe, detected, big_endian, pready;
	logic [3:0] field_offset;
	logic [2:0] field_width;
	logic signed [16:0] adjustment;
	logic [16:0] message_total;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;

	batch_scoreboard sb;
	int idle_pct;
	int cycles;

	length_field_inference uut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Bound the run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Check every strobed result
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result('{detected, field_offset, field_width, big_endian,
				adjustment, message_total});
	end

	task automatic write_min_cov(int unsigned pct);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= REG_MIN_COV;
		pwdata <= pct;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.cov_pct = pct & 32'h7f;
	endtask

	// Offer one message, hold until accepted, then idle at random
	task automatic send_message(logic [63:0] lo, logic [63:0] hi, logic [15:0] len,
			logic last);
		start <= 1;
		header_low <= lo;
		header_high <= hi;
		payload_length <= len;
		last_message <= last;
		do @(posedge clk); while (busy);
		sb.note_message(lo, hi, len, last);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Batch built around a planted length field, with noisy messages mixed in
	task automatic planted_batch(int n);
		int off, w, be, k, nz;
		logic [127:0] hdr;
		int unsigned len, fv;
		w = 1 << $urandom_range(2);
		off = $urandom_range(16 - w);
		be = $urandom_range(1);
		k = ($urandom_range(3) == 0) ? -$urandom_range(20) : $urandom_range(40);
		nz = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			hdr = {$urandom, $urandom, $urandom, $urandom};
			len = $urandom_range(($urandom_range(3) == 0) ? 65535 : 600);
			if ($urandom_range(9) >= nz) begin
				fv = (int'(len) >= k) ? len - k : 0;
				if (w == 1) fv &= 8'hff;
				else if (w == 2) fv &= 16'hffff;
				len = fv + k;
				if (len > 65535) len = 65535;
				fv = len - k;
				for (int b = 0; b < w; b++)
					hdr[8*(off + (be ? w-1-b : b)) +: 8] = 8'(fv >> (8*b));
			end
			send_message(hdr[63:0], hdr[127:64], 16'(len), i == n - 1);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		start = 0;
		header_low = 0;
		header_high = 0;
		payload_length = 0;
		last_message = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: short batches, zero and full fields, length extremes
		send_message('0, '0, 16'd0, 1);
		send_message('1, '1, 16'hffff, 0);
		send_message('1, '1, 16'hffff, 0);
		send_message('0, '0, 16'd0, 1);
		for (int i = 0; i < 5; i++)
			send_message({56'd0, 8'(i + 20)}, '0, 16'(i + 20 + 4), i == 4);
		for (int i = 0; i < 6; i++)
			send_message('1, '1, 16'hffff, i == 5);
		for (int i = 0; i < 4; i++)
			send_message({48'd0, 16'(i + 1)}, '0, 16'(i + 1), i == 3);
		drain();

		// Random: sweep coverage settings and idling phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 78;
				2: idle_pct = 0;
				default: idle_pct = 26;
			endcase
			case (ph)
				0: write_min_cov(0);
				1: write_min_cov(100);
				2: write_min_cov(127);
				3: write_min_cov(80);
				default: write_min_cov($urandom_range(127));
			endcase
			for (int b = 0; b < 18; b++)
				planted_batch(($urandom_range(9) == 0) ? $urandom_range(3, 1)
					: $urandom_range(20, 4));
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

### filelist.f
hw/rtl/lfi_pkg.sv
hw/rtl/lfi_lane.sv
hw/rtl/lfi_merge.sv
hw/rtl/length_field_inference.sv
bench/tb_length_field_inference.sv
